// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/esa_pkg.sv =====
`timescale 1ns / 1ps
package esa_pkg;

  localparam int RECORDS_DEF   = 64;
  localparam int SIZE_BITS_DEF = 32;
  localparam int CFG_IDX_W     = 4;

  localparam logic [31:0] EXTENT_RST = 32'd65536;
  localparam logic [4:0]  ALIGN_RST  = 5'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ALIGN  = CFG_IDX_W'(1);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;
  localparam logic [1:0] ST_BADID = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] req_size;
    logic [5:0]  free_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  block_id;
    logic [31:0] origin;
    logic [31:0] granted_size;
    logic [31:0] bytes_in_use;
  } res_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CLEAR, OP_SCAN, OP_EX0, OP_FIX0, OP_FIX1,
    OP_SP0, OP_SP1, OP_SP2, OP_SP3,
    OP_FR0, OP_FR1, OP_FR2, OP_FR3, OP_FR4,
    OP_FZ0, OP_FP0, OP_FP1, OP_FN0, OP_FN1, OP_FB0, OP_FB1, OP_RES
  } op_e;

  typedef struct packed {
    op_e  op;
    logic accept;
  } cmd_t;

  typedef struct packed {
    logic restart;
    logic clr_last;
    logic in_free;
    logic bad_id;
    logic hit_exact;
    logic hit_split;
    logic scan_done;
    logic cur_busy;
    logic p_free;
    logic n_free;
    logic slot_ne;
  } sts_t;

endpackage

// ===== rtl/esa_ram.sv =====
`timescale 1ns / 1ps
module esa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/esa_ctrl.sv =====
`timescale 1ns / 1ps
module esa_ctrl import esa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic done_o
);

  localparam logic [4:0] S_IDLE = 5'd0,  S_CLEAR = 5'd1,  S_SCAN = 5'd2,  S_EX0 = 5'd3;
  localparam logic [4:0] S_FIX0 = 5'd4,  S_FIX1 = 5'd5,   S_SP0 = 5'd6,   S_SP1 = 5'd7;
  localparam logic [4:0] S_SP2 = 5'd8,   S_SP3 = 5'd9,    S_FR0 = 5'd10,  S_FR1 = 5'd11;
  localparam logic [4:0] S_FR2 = 5'd12,  S_FR3 = 5'd13,   S_FR4 = 5'd14,  S_FZ0 = 5'd15;
  localparam logic [4:0] S_FP0 = 5'd16,  S_FP1 = 5'd17,   S_FN0 = 5'd18,  S_FN1 = 5'd19;
  localparam logic [4:0] S_FB0 = 5'd20,  S_FB1 = 5'd21,   S_RES = 5'd22;

  logic [4:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.op = OP_IDLE;
    cmd_o.accept = (state_q == S_IDLE) && start_i;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.op = OP_IDLE;
        if (start_i) state_d = sts_i.in_free ? S_FR0 : S_SCAN;
      end
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (sts_i.hit_exact) state_d = S_EX0;
        else if (sts_i.hit_split) state_d = S_SP0;
        else if (sts_i.scan_done) state_d = S_RES;
      end
      S_EX0: begin
        cmd_o.op = OP_EX0;
        state_d = S_FIX0;
      end
      S_FIX0: begin
        cmd_o.op = OP_FIX0;
        state_d = sts_i.slot_ne ? S_FIX1 : S_RES;
      end
      S_FIX1: begin
        cmd_o.op = OP_FIX1;
        state_d = S_RES;
      end
      S_SP0: begin
        cmd_o.op = OP_SP0;
        state_d = S_SP1;
      end
      S_SP1: begin
        cmd_o.op = OP_SP1;
        state_d = S_SP2;
      end
      S_SP2: begin
        cmd_o.op = OP_SP2;
        state_d = S_SP3;
      end
      S_SP3: begin
        cmd_o.op = OP_SP3;
        state_d = S_RES;
      end
      S_FR0: begin
        cmd_o.op = OP_FR0;
        state_d = sts_i.bad_id ? S_RES : S_FR1;
      end
      S_FR1: begin
        cmd_o.op = OP_FR1;
        state_d = sts_i.cur_busy ? S_FR2 : S_RES;
      end
      S_FR2: begin
        cmd_o.op = OP_FR2;
        state_d = S_FR3;
      end
      S_FR3: begin
        cmd_o.op = OP_FR3;
        state_d = S_FR4;
      end
      S_FR4: begin
        cmd_o.op = OP_FR4;
        if (sts_i.p_free && sts_i.n_free) state_d = S_FB0;
        else if (sts_i.p_free) state_d = S_FP0;
        else if (sts_i.n_free) state_d = S_FN0;
        else state_d = S_FZ0;
      end
      S_FZ0: begin
        cmd_o.op = OP_FZ0;
        state_d = S_RES;
      end
      S_FP0: begin
        cmd_o.op = OP_FP0;
        state_d = S_FP1;
      end
      S_FP1: begin
        cmd_o.op = OP_FP1;
        state_d = S_RES;
      end
      S_FN0: begin
        cmd_o.op = OP_FN0;
        state_d = S_FN1;
      end
      S_FN1: begin
        cmd_o.op = OP_FN1;
        state_d = S_RES;
      end
      S_FB0: begin
        cmd_o.op = OP_FB0;
        state_d = S_FB1;
      end
      S_FB1: begin
        cmd_o.op = OP_FB1;
        state_d = S_FIX0;
      end
      S_RES: begin
        cmd_o.op = OP_RES;
        state_d = S_IDLE;
      end
      default: begin
        cmd_o.op = OP_IDLE;
        state_d = S_CLEAR;
      end
    endcase
    // extent write rebuilds the table
    if (sts_i.restart) state_d = S_CLEAR;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/esa_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module esa_dp import esa_pkg::*; #(
  parameter int RECORDS   = RECORDS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  req_t                 req_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output res_t                 res_o
);

  localparam int IDW = $clog2(RECORDS);
  localparam int CW  = $clog2(RECORDS + 1);
  localparam int S   = SIZE_BITS;
  localparam logic [CW-1:0] NIL = CW'(RECORDS);

  typedef struct packed {
    logic [S-1:0]   len;
    logic [S-1:0]   start;
    logic [CW-1:0]  left;
    logic [CW-1:0]  right;
    logic           busy;
    logic [IDW-1:0] slot;
  } rec_t;

  // record and order memories
  logic           rec_we, ord_we;
  logic [IDW-1:0] rec_waddr, rec_raddr, ord_waddr, ord_raddr;
  rec_t           rec_wdata, rec_rdata;
  logic [IDW-1:0] ord_wdata, ord_rdata;

  esa_ram #(.WIDTH($bits(rec_t)), .DEPTH(RECORDS)) u_rec_ram (
    .clk_i, .we_i(rec_we), .waddr_i(rec_waddr), .wdata_i(rec_wdata),
    .raddr_i(rec_raddr), .rdata_o(rec_rdata)
  );

  esa_ram #(.WIDTH(IDW), .DEPTH(RECORDS)) u_ord_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(ord_wdata),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  logic [31:0]    extent_q;
  logic [4:0]     align_q;
  logic [CW-1:0]  fc_q, fc_d, spare_q, spare_d, i_q, i_d;
  logic [S-1:0]   used_q, used_d, rnd_q, rnd_d;
  logic [IDW-1:0] clr_q, clr_d, id_q, id_d, slot_q, slot_d, ax_q, ax_d;
  logic [IDW-1:0] i1_q, i1_d, i2_q, i2_d, id2_q, id2_d;
  logic           v1_q, v1_d, v2_q, v2_d, ovf_q, ovf_d, bad_q, bad_d;
  rec_t           cur_q, cur_d, prec_q, prec_d, nrec_q, nrec_d;
  logic [1:0]     rst_q, rst_d;
  logic [5:0]     rid_q, rid_d;
  logic [31:0]    rorg_q, rorg_d, rsz_q, rsz_d;

  logic           restart;
  logic [32:0]    amask, rsum, rnd33;
  logic           ovf_in;
  logic           scan_avail, hit_exact, hit_split;
  logic [IDW-1:0] spare_top, push_addr, fc_last;
  logic           p_valid, n_valid;

  assign restart = cfg_valid_i && (cfg_index_i == CFG_EXTENT);

  // round the request up to the granule
  assign amask  = (33'd1 << align_q) - 33'd1;
  assign rsum   = {1'b0, req_i.req_size} + amask;
  assign rnd33  = rsum & ~amask;
  assign ovf_in = (rnd33 >> S) != 33'd0;

  assign scan_avail = (i_q < fc_q) && !ovf_q;
  assign hit_exact  = (cmd_i.op == OP_SCAN) && v2_q && (rec_rdata.len == rnd_q);
  assign hit_split  = (cmd_i.op == OP_SCAN) && v2_q && !hit_exact &&
                      (rec_rdata.len > rnd_q) && (spare_q != '0);

  assign spare_top = IDW'(NIL - spare_q);
  assign push_addr = IDW'(NIL - spare_q - CW'(1));
  assign fc_last   = IDW'(fc_q - CW'(1));
  assign p_valid   = cur_q.left < NIL;
  assign n_valid   = cur_q.right < NIL;

  always_comb begin
    sts_o.restart   = restart;
    sts_o.clr_last  = clr_q == IDW'(RECORDS - 1);
    sts_o.in_free   = req_i.kind == KIND_FREE;
    sts_o.bad_id    = bad_q;
    sts_o.hit_exact = hit_exact;
    sts_o.hit_split = hit_split;
    sts_o.scan_done = !scan_avail && !v1_q && !v2_q;
    sts_o.cur_busy  = rec_rdata.busy;
    sts_o.p_free    = p_valid && !prec_q.busy;
    sts_o.n_free    = n_valid && !nrec_q.busy;
    sts_o.slot_ne   = CW'(slot_q) != fc_q;
  end

  always_comb begin
    rec_we = 1'b0; rec_waddr = id_q; rec_wdata = cur_q; rec_raddr = id_q;
    ord_we = 1'b0; ord_waddr = push_addr; ord_wdata = id_q; ord_raddr = fc_last;
    fc_d = fc_q; spare_d = spare_q; i_d = i_q; used_d = used_q; rnd_d = rnd_q;
    clr_d = clr_q; id_d = id_q; slot_d = slot_q; ax_d = ax_q;
    i1_d = i1_q; i2_d = i2_q; id2_d = id2_q; v1_d = v1_q; v2_d = v2_q;
    ovf_d = ovf_q; bad_d = bad_q;
    cur_d = cur_q; prec_d = prec_q; nrec_d = nrec_q;
    rst_d = rst_q; rid_d = rid_q; rorg_d = rorg_q; rsz_d = rsz_q;

    unique case (cmd_i.op)
      OP_IDLE: begin
        if (cmd_i.accept) begin
          i_d = '0; v1_d = 1'b0; v2_d = 1'b0;
          rnd_d = S'(rnd33); ovf_d = ovf_in;
          id_d = IDW'(req_i.free_id);
          bad_d = {26'd0, req_i.free_id} >= 32'(RECORDS);
          rorg_d = '0;
          if (req_i.kind == KIND_FREE) begin
            rst_d = ST_BADID; rid_d = req_i.free_id; rsz_d = '0;
          end else begin
            rst_d = ST_NOFIT; rid_d = '0;
            rsz_d = ovf_in ? '1 : rnd33[31:0];
          end
        end
      end
      OP_CLEAR: begin
        rec_we = 1'b1; rec_waddr = clr_q;
        rec_wdata = '{len: (clr_q == '0) ? S'(extent_q) : '0, start: '0,
                      left: NIL, right: NIL, busy: 1'b0, slot: '0};
        ord_we = 1'b1; ord_waddr = clr_q; ord_wdata = clr_q;
        clr_d = clr_q + IDW'(1);
      end
      OP_SCAN: begin
        // order read, then record read, then compare
        ord_raddr = i_q[IDW-1:0];
        rec_raddr = ord_rdata;
        if (hit_exact || hit_split) begin
          cur_d = rec_rdata; id_d = id2_q; slot_d = i2_q;
          v1_d = 1'b0; v2_d = 1'b0;
        end else begin
          v1_d = scan_avail; i1_d = i_q[IDW-1:0];
          i_d = i_q + CW'(scan_avail);
          v2_d = v1_q; i2_d = i1_q; id2_d = ord_rdata;
        end
      end
      OP_EX0: begin
        rec_we = 1'b1; rec_waddr = id_q;
        rec_wdata = cur_q; rec_wdata.busy = 1'b1;
        used_d = used_q + rnd_q;
        fc_d = fc_q - CW'(1);
        ord_raddr = fc_last;
        rst_d = ST_ALLOC; rid_d = 6'(id_q); rorg_d = 32'(cur_q.start);
      end
      OP_FIX0: begin
        // move the last free entry into the vacated slot
        ax_d = ord_rdata;
        rec_raddr = ord_rdata;
        if (CW'(slot_q) != fc_q) begin
          ord_we = 1'b1; ord_waddr = slot_q; ord_wdata = ord_rdata;
        end
      end
      OP_FIX1: begin
        rec_we = 1'b1; rec_waddr = ax_q;
        rec_wdata = rec_rdata; rec_wdata.slot = slot_q;
      end
      OP_SP0: begin
        ord_raddr = spare_top;
        rec_raddr = cur_q.left[IDW-1:0];
        spare_d = spare_q - CW'(1);
        used_d = used_q + rnd_q;
        rst_d = ST_ALLOC; rorg_d = 32'(cur_q.start);
      end
      OP_SP1: begin
        ax_d = ord_rdata; rid_d = 6'(ord_rdata);
        if (p_valid) begin
          rec_we = 1'b1; rec_waddr = cur_q.left[IDW-1:0];
          rec_wdata = rec_rdata; rec_wdata.right = CW'(ord_rdata);
        end
      end
      OP_SP2: begin
        rec_we = 1'b1; rec_waddr = ax_q;
        rec_wdata = '{len: rnd_q, start: cur_q.start, left: cur_q.left,
                      right: CW'(id_q), busy: 1'b1, slot: '0};
      end
      OP_SP3: begin
        rec_we = 1'b1; rec_waddr = id_q;
        rec_wdata = cur_q;
        rec_wdata.left = CW'(ax_q);
        rec_wdata.len = cur_q.len - rnd_q;
        rec_wdata.start = cur_q.start + rnd_q;
      end
      OP_FR0: begin
        rec_raddr = id_q;
      end
      OP_FR1: begin
        cur_d = rec_rdata;
        rec_raddr = rec_rdata.left[IDW-1:0];
        if (rec_rdata.busy) begin
          rst_d = ST_FREED;
          rorg_d = 32'(rec_rdata.start);
          rsz_d = 32'(rec_rdata.len);
          used_d = used_q - rec_rdata.len;
        end
      end
      OP_FR2: begin
        prec_d = rec_rdata;
        rec_raddr = cur_q.right[IDW-1:0];
      end
      OP_FR3: begin
        nrec_d = rec_rdata;
      end
      OP_FR4: begin
        rec_we = 1'b1; rec_waddr = id_q;
        rec_wdata = cur_q; rec_wdata.busy = 1'b0;
        rec_wdata.slot = fc_q[IDW-1:0];
      end
      OP_FZ0: begin
        ord_we = 1'b1; ord_waddr = fc_q[IDW-1:0]; ord_wdata = id_q;
        fc_d = fc_q + CW'(1);
      end
      OP_FP0: begin
        rec_we = 1'b1; rec_waddr = cur_q.left[IDW-1:0];
        rec_wdata = prec_q;
        rec_wdata.len = prec_q.len + cur_q.len;
        rec_wdata.right = cur_q.right;
      end
      OP_FP1: begin
        if (n_valid) begin
          rec_we = 1'b1; rec_waddr = cur_q.right[IDW-1:0];
          rec_wdata = nrec_q; rec_wdata.left = cur_q.left;
        end
        ord_we = 1'b1; ord_waddr = push_addr; ord_wdata = id_q;
        spare_d = spare_q + CW'(1);
      end
      OP_FN0: begin
        rec_we = 1'b1; rec_waddr = cur_q.right[IDW-1:0];
        rec_wdata = nrec_q;
        rec_wdata.left = cur_q.left;
        rec_wdata.start = cur_q.start;
        rec_wdata.len = nrec_q.len + cur_q.len;
        ord_we = 1'b1; ord_waddr = push_addr; ord_wdata = id_q;
        spare_d = spare_q + CW'(1);
      end
      OP_FN1: begin
        if (p_valid) begin
          rec_we = 1'b1; rec_waddr = cur_q.left[IDW-1:0];
          rec_wdata = prec_q; rec_wdata.right = cur_q.right;
        end
      end
      OP_FB0: begin
        // left absorbs this block and the right one
        rec_we = 1'b1; rec_waddr = cur_q.left[IDW-1:0];
        rec_wdata = prec_q;
        rec_wdata.len = prec_q.len + cur_q.len + nrec_q.len;
        rec_wdata.right = nrec_q.right;
        rec_raddr = nrec_q.right[IDW-1:0];
        ord_we = 1'b1; ord_waddr = push_addr; ord_wdata = cur_q.right[IDW-1:0];
        spare_d = spare_q + CW'(1);
        slot_d = nrec_q.slot;
      end
      OP_FB1: begin
        if (nrec_q.right < NIL) begin
          rec_we = 1'b1; rec_waddr = nrec_q.right[IDW-1:0];
          rec_wdata = rec_rdata; rec_wdata.left = cur_q.left;
        end
        ord_we = 1'b1; ord_waddr = push_addr; ord_wdata = id_q;
        spare_d = spare_q + CW'(1);
        fc_d = fc_q - CW'(1);
        ord_raddr = fc_last;
      end
      OP_RES: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      extent_q <= EXTENT_RST;
      align_q  <= ALIGN_RST;
      clr_q    <= '0;
      fc_q     <= CW'(1);
      spare_q  <= CW'(RECORDS - 1);
      used_q   <= '0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
    end else begin
      clr_q   <= clr_d;
      fc_q    <= fc_d;
      spare_q <= spare_d;
      used_q  <= used_d;
      v1_q    <= v1_d;
      v2_q    <= v2_d;
      if (cfg_valid_i && (cfg_index_i == CFG_ALIGN)) begin
        align_q <= cfg_data_i[4:0];
      end
      if (restart) begin
        extent_q <= cfg_data_i;
        clr_q    <= '0;
        fc_q     <= CW'(1);
        spare_q  <= CW'(RECORDS - 1);
        used_q   <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; rnd_q <= rnd_d; id_q <= id_d; slot_q <= slot_d; ax_q <= ax_d;
    i1_q <= i1_d; i2_q <= i2_d; id2_q <= id2_d; ovf_q <= ovf_d; bad_q <= bad_d;
    cur_q <= cur_d; prec_q <= prec_d; nrec_q <= nrec_d;
    rst_q <= rst_d; rid_q <= rid_d; rorg_q <= rorg_d; rsz_q <= rsz_d;
  end

  always_comb begin
    res_o.status       = rst_q;
    res_o.block_id     = rid_q;
    res_o.origin       = rorg_q;
    res_o.granted_size = rsz_q;
    res_o.bytes_in_use = 32'(used_q);
  end

  `ASSERT_NEVER(a_rec_overcount, ({1'b0, fc_q} + {1'b0, spare_q}) > (CW + 1)'(RECORDS), "free plus spare records exceed the pool")
  `ASSERT_NEVER(a_hit_both, hit_exact && hit_split, "scan reports exact fit and split at once")

endmodule

// ===== rtl/extent_suballocator_core.sv =====
`timescale 1ns / 1ps
// First-fit allocator over one extent with a pool of RECORDS block records.
// A request is taken when start is high and busy is low; its one result
// appears for a single cycle with done_o high and cannot be held off.
// A free of a block in use releases it and merges it with each free
// neighbor. An allocation scans the free records in free-list order; the
// scan walks the free-list order memory and the record memory one entry
// per cycle.
// After reset and after every extent_size write the tables are rebuilt by a
// pass over all RECORDS entries, during which busy stays high; configuration
// writes are taken only while busy and start are both low.
`include "assert_macros.svh"
module extent_suballocator_core import esa_pkg::*; #(
  parameter int RECORDS   = RECORDS_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 done_o,
  output res_t                 res_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // no config write while a request is in flight or being taken
  assign cfg_ready_o = !busy && !start;

  esa_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .cmd_o(cmd),
    .busy_o(busy), .done_o
  );

  esa_dp #(.RECORDS(RECORDS), .SIZE_BITS(SIZE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .req_i,
    .cfg_valid_i(cfg_valid_i && cfg_ready_o), .cfg_index_i, .cfg_data_i, .res_o
  );

  `ASSERT_AT(a_done_single, done_o |=> !done_o, "result strobe longer than one cycle")
  `ASSERT_AT(a_accept_busy, (start && !busy) |=> busy, "request taken without going busy")
  `ASSERT_NEVER(a_done_idle, done_o && !busy, "result while idle")

endmodule
